// ===== design/dnle_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS name label encoder package
// Shared widths, constants and the command and status types that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package dnle_pkg;

  localparam int unsigned ByteW           = 8;
  localparam int unsigned CountW          = 6;
  localparam int unsigned StoreDepth      = 62;
  localparam int unsigned MaxLabelDefault = 62;

  localparam logic [ByteW-1:0] DotChar    = 8'h2E;
  localparam logic [ByteW-1:0] Terminator = 8'h00;

  typedef struct packed {
    logic store_wr;
    logic load_len;
    logic load_char;
    logic load_term;
    logic clear_label;
    logic out_last;
  } dnle_cmd_t;

  typedef struct packed {
    logic              out_free;
    logic              count_zero;
    logic              last_char;
    logic [CountW-1:0] count;
  } dnle_stat_t;

endpackage

// ===== design/dnle_dpath.sv =====
// ----------------------------------------------------------------------------
// DNS name label encoder datapath
// Holds the label store, the character count, the overflow flag and the
// output register, and acts on the controller's commands.
// ----------------------------------------------------------------------------
module dnle_dpath #(
  parameter int unsigned MAX_LABEL = dnle_pkg::MaxLabelDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [dnle_pkg::ByteW-1:0] character_i,
  input  logic                       out_ready_i,
  input  dnle_pkg::dnle_cmd_t        cmd_i,
  output dnle_pkg::dnle_stat_t       stat_o,
  output logic                       out_valid_o,
  output logic [dnle_pkg::ByteW-1:0] out_byte_o,
  output logic                       last_o,
  output logic                       label_overflow_o
);

  localparam int unsigned LimitInt =
    (MAX_LABEL > dnle_pkg::StoreDepth) ? dnle_pkg::StoreDepth :
    (MAX_LABEL < 1) ? 1 : MAX_LABEL;
  localparam logic [dnle_pkg::CountW-1:0] Limit = dnle_pkg::CountW'(LimitInt);

  logic [dnle_pkg::ByteW-1:0]  store_q [dnle_pkg::StoreDepth];
  logic [dnle_pkg::ByteW-1:0]  rdata_q;
  logic [dnle_pkg::CountW-1:0] rd_addr;

  logic [dnle_pkg::CountW-1:0] count_q, count_d;
  logic [dnle_pkg::CountW-1:0] idx_q, idx_d;
  logic                        ovf_q, ovf_d;

  logic                        out_valid_q, out_valid_d;
  logic [dnle_pkg::ByteW-1:0]  out_byte_q;
  logic                        out_last_q;
  logic                        out_ovf_q;
  logic                        load_any;
  logic                        last_char;

  assign last_char = (dnle_pkg::CountW'(idx_q + 1'b1) == count_q);
  assign load_any  = cmd_i.load_len | cmd_i.load_char | cmd_i.load_term;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.clear_label) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.store_wr) begin
      if (count_q < Limit) begin
        count_d = dnle_pkg::CountW'(count_q + 1'b1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_comb begin
    idx_d   = idx_q;
    rd_addr = idx_q;
    if (cmd_i.load_len) begin
      idx_d   = '0;
      rd_addr = '0;
    end else if (cmd_i.load_char && !last_char) begin
      idx_d   = dnle_pkg::CountW'(idx_q + 1'b1);
      rd_addr = dnle_pkg::CountW'(idx_q + 1'b1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_any) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr && (count_q < Limit)) begin
      store_q[count_q] <= character_i;
    end
    rdata_q <= store_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (load_any) begin
      out_last_q <= cmd_i.out_last;
      out_ovf_q  <= ovf_q;
      priority if (cmd_i.load_len) begin
        out_byte_q <= dnle_pkg::ByteW'(count_q);
      end else if (cmd_i.load_char) begin
        out_byte_q <= rdata_q;
      end else begin
        out_byte_q <= dnle_pkg::Terminator;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.last_char  = last_char;
  assign stat_o.count      = count_q;

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign last_o           = out_last_q;
  assign label_overflow_o = out_ovf_q;

endmodule

// ===== design/dnle_ctrl.sv =====
// ----------------------------------------------------------------------------
// DNS name label encoder controller
// Takes input items and sequences each label flush: length byte, label
// characters and, at the end of a name, the zero terminator.
// ----------------------------------------------------------------------------
module dnle_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [dnle_pkg::ByteW-1:0] character_i,
  input  logic                       end_of_name_i,
  input  dnle_pkg::dnle_stat_t       stat_i,
  output dnle_pkg::dnle_cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StLen   = 4'b0010,
    StChars = 4'b0100,
    StTerm  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   end_q, end_d;

  always_comb begin
    state_d    = state_q;
    end_d      = end_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (end_of_name_i) begin
            end_d   = 1'b1;
            state_d = StLen;
          end else if (character_i == dnle_pkg::DotChar) begin
            end_d   = 1'b0;
            state_d = StLen;
          end else begin
            cmd_o.store_wr = 1'b1;
          end
        end
      end
      StLen: begin
        if (stat_i.out_free) begin
          cmd_o.load_len = 1'b1;
          cmd_o.out_last = !end_q && stat_i.count_zero;
          if (!stat_i.count_zero) begin
            state_d = StChars;
          end else if (end_q) begin
            state_d = StTerm;
          end else begin
            cmd_o.clear_label = 1'b1;
            state_d           = StIdle;
          end
        end
      end
      StChars: begin
        if (stat_i.out_free) begin
          cmd_o.load_char = 1'b1;
          cmd_o.out_last  = !end_q && stat_i.last_char;
          if (stat_i.last_char) begin
            if (end_q) begin
              state_d = StTerm;
            end else begin
              cmd_o.clear_label = 1'b1;
              state_d           = StIdle;
            end
          end
        end
      end
      StTerm: begin
        if (stat_i.out_free) begin
          cmd_o.load_term   = 1'b1;
          cmd_o.out_last    = 1'b1;
          cmd_o.clear_label = 1'b1;
          state_d           = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
    end
  end

endmodule

// ===== design/dns_name_label_encoder_top.sv =====
// A character goes into the label store while the label limit allows. A dot
// or an end of name starts a flush of the length byte and the buffered label
// characters, plus the zero terminator for an end of name, with input held
// off until the flush is done. The length byte is registered; then one byte
// moves per cycle while the consumer is ready. Reset clears the controller,
// the count, the overflow flag and output valid; the label store is not cleared.
// ----------------------------------------------------------------------------
// DNS name label encoder top level
// Turns a dotted host name, one character per transfer, into DNS wire-format
// labels with a zero terminator.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_top #(
  parameter int unsigned MAX_LABEL = dnle_pkg::MaxLabelDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [dnle_pkg::ByteW-1:0] character_i,
  input  logic                       end_of_name_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dnle_pkg::ByteW-1:0] out_byte_o,
  output logic                       last_o,
  output logic                       label_overflow_o
);

  localparam int unsigned LabelLimit =
    (MAX_LABEL > dnle_pkg::StoreDepth) ? dnle_pkg::StoreDepth :
    (MAX_LABEL < 1) ? 1 : MAX_LABEL;

  dnle_pkg::dnle_cmd_t  cmd;
  dnle_pkg::dnle_stat_t stat;

  dnle_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .character_i   (character_i),
    .end_of_name_i (end_of_name_i),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  dnle_dpath #(
    .MAX_LABEL (MAX_LABEL)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .character_i      (character_i),
    .out_ready_i      (out_ready_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .label_overflow_o (label_overflow_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.count <= dnle_pkg::CountW'(LabelLimit)))
    else $error("Label count exceeds the label limit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o &&
     (end_of_name_i || (character_i == dnle_pkg::DotChar))) |=> !in_ready_o)
    else $error("Input taken while a label flush is pending.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_term |=> (out_valid_o && last_o && (out_byte_o == dnle_pkg::Terminator)))
    else $error("Terminator byte not presented as the last byte.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store_wr |-> (in_valid_i && in_ready_o && !end_of_name_i))
    else $error("Label store written without an input transfer.");

endmodule

// ===== tb/sv/tb_dns_name_label_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS name label encoder testbench
// Feeds dotted host names and malformed character streams into the encoder
// under changing input and output idling, predicts every wire-format byte in
// a scoreboard and compares each output transfer field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [dnle_pkg::ByteW-1:0] out_byte;
  logic                       last;
  logic                       label_overflow;
} wire_byte_t;

class label_scoreboard;
  logic [dnle_pkg::ByteW-1:0] label_chars [dnle_pkg::StoreDepth];
  int unsigned label_len;
  bit          label_dropped;
  int unsigned label_limit;
  wire_byte_t  wire_q [$];
  int unsigned errors;
  int unsigned bytes_checked;
  int unsigned names_done;
  int unsigned overflow_labels;
  int unsigned empty_labels;

  function new(int unsigned max_label);
    label_limit = max_label;
    if (label_limit > dnle_pkg::StoreDepth) label_limit = dnle_pkg::StoreDepth;
    if (label_limit < 1) label_limit = 1;
  endfunction

  function int unsigned pending();
    return wire_q.size();
  endfunction

  function void flush_label(bit mark_last);
    wire_byte_t wb;
    wb.out_byte       = label_len[dnle_pkg::ByteW-1:0];
    wb.last           = mark_last && (label_len == 0);
    wb.label_overflow = label_dropped;
    wire_q.push_back(wb);
    for (int i = 0; i < label_len; i++) begin
      wb.out_byte = label_chars[i];
      wb.last     = mark_last && (i + 1 == label_len);
      wire_q.push_back(wb);
    end
    if (label_dropped) overflow_labels++;
    if (label_len == 0) empty_labels++;
    label_len     = 0;
    label_dropped = 1'b0;
  endfunction

  function void note_input(logic [dnle_pkg::ByteW-1:0] ch, logic eon);
    wire_byte_t term;
    if (eon) begin
      term = '{out_byte: dnle_pkg::Terminator, last: 1'b1, label_overflow: label_dropped};
      flush_label(1'b0);
      wire_q.push_back(term);
      names_done++;
    end else if (ch == dnle_pkg::DotChar) begin
      flush_label(1'b1);
    end else if (label_len < label_limit) begin
      label_chars[label_len] = ch;
      label_len++;
    end else begin
      label_dropped = 1'b1;
    end
  endfunction

  function void check_result(logic [dnle_pkg::ByteW-1:0] got_byte, logic got_last,
                             logic got_ovf);
    wire_byte_t want;
    bytes_checked++;
    if (wire_q.size() == 0) begin
      $error("unexpected output transfer: out_byte %02h last %0b label_overflow %0b",
             got_byte, got_last, got_ovf);
      errors++;
      return;
    end
    want = wire_q.pop_front();
    if (got_byte !== want.out_byte) begin
      $error("out_byte mismatch: expected %02h, actual %02h", want.out_byte, got_byte);
      errors++;
    end
    if (got_last !== want.last) begin
      $error("last mismatch: expected %0b, actual %0b", want.last, got_last);
      errors++;
    end
    if (got_ovf !== want.label_overflow) begin
      $error("label_overflow mismatch: expected %0b, actual %0b", want.label_overflow,
             got_ovf);
      errors++;
    end
  endfunction
endclass

module tb_dns_name_label_encoder_top;

  localparam int unsigned LabelLimit     = dnle_pkg::MaxLabelDefault;
  localparam int unsigned PhaseItems     = 65;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned TailCycles     = 80;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_ready_o;
  logic [dnle_pkg::ByteW-1:0] character_i   = '0;
  logic                       end_of_name_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i   = 1'b0;
  logic [dnle_pkg::ByteW-1:0] out_byte_o;
  logic                       last_o;
  logic                       label_overflow_o;

  int unsigned tx_idle_pct     = 0;
  int unsigned rx_idle_pct     = 0;
  bit          long_hold_armed = 1'b0;
  int unsigned items_sent      = 0;
  label_scoreboard sb;

  dns_name_label_encoder_top #(
    .MAX_LABEL(LabelLimit)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .character_i      (character_i),
    .end_of_name_i    (end_of_name_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .label_overflow_o (label_overflow_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin : rx_driver
    int unsigned hold_left;
    bit          hold_done;
    if (rst_ni) begin
      if (long_hold_armed && !hold_done) begin
        hold_left = LongHoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_byte_o, last_o, label_overflow_o);
      if (in_valid_i && in_ready_o) sb.note_input(character_i, end_of_name_i);
    end
  end

  function automatic logic [dnle_pkg::ByteW-1:0] rand_label_char();
    logic [dnle_pkg::ByteW-1:0] c;
    do c = dnle_pkg::ByteW'($urandom_range(255)); while (c == dnle_pkg::DotChar);
    return c;
  endfunction

  task automatic send_item(input logic [dnle_pkg::ByteW-1:0] ch, input logic eon);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    character_i   <= ch;
    end_of_name_i <= eon;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_name(input int first_len, input int unsigned n_labels);
    int unsigned labels;
    int          len;
    labels = (n_labels != 0) ? n_labels : $urandom_range(4, 1);
    for (int k = 0; k < labels; k++) begin
      if (k == 0 && first_len >= 0) len = first_len;
      else if ($urandom_range(99) < 3) len = $urandom_range(66, 58);
      else len = $urandom_range(7, 0);
      repeat (len) send_item(rand_label_char(), 1'b0);
      if (k + 1 < labels) send_item(dnle_pkg::DotChar, 1'b0);
    end
    if ($urandom_range(99) < 10) send_item(dnle_pkg::DotChar, 1'b0);
    send_item(($urandom_range(3) == 0) ? dnle_pkg::DotChar :
              dnle_pkg::ByteW'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(10, 3)) begin
      case ($urandom_range(7))
        0, 1:    send_item(dnle_pkg::DotChar, 1'b0);
        2:       send_item(dnle_pkg::ByteW'($urandom_range(255)), 1'b1);
        default: send_item(dnle_pkg::ByteW'($urandom_range(255)), 1'b0);
      endcase
    end
  endtask

  task automatic run_phase(input int unsigned tx, input int unsigned rx,
                           input int forced_len, input int unsigned forced_labels);
    int unsigned stop_at;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    stop_at     = items_sent + PhaseItems;
    send_name(forced_len, forced_labels);
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) send_noise();
      else send_name(-1, 0);
    end
    drain();
  endtask

  initial begin : stimulus
    sb = new(LabelLimit);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty names, leading and doubled dots, end right after a dot, and the
    // extreme and dot-adjacent character values.
    send_item(dnle_pkg::DotChar, 1'b1);
    send_item(dnle_pkg::DotChar, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h61, 1'b0);
    send_item(dnle_pkg::DotChar, 1'b0);
    send_item(dnle_pkg::DotChar, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(dnle_pkg::DotChar, 1'b0);
    send_item(8'h2D, 1'b0);
    send_item(8'h2F, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(dnle_pkg::DotChar, 1'b0);
    send_item(8'h55, 1'b1);
    drain();

    long_hold_armed = 1'b1;
    run_phase(11, 64, LabelLimit + 1, 1);
    run_phase(64, 11, LabelLimit + 1, 2);
    run_phase(0, 0, LabelLimit, 2);

    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending() != 0) $error("%0d expected output bytes never arrived", sb.pending());
    $display("Sent %0d input transfers forming %0d names; checked %0d output bytes.",
             items_sent, sb.names_done, sb.bytes_checked);
    $display("Saw %0d empty and %0d overflowed labels, one %0d-cycle output stall.",
             sb.empty_labels, sb.overflow_labels, LongHoldCycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("dns_name_label_encoder_top verification clean");
    end else begin
      $display("dns_name_label_encoder_top verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("dns_name_label_encoder_top verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/dnle_pkg.sv
design/dnle_dpath.sv
design/dnle_ctrl.sv
design/dns_name_label_encoder_top.sv
tb/sv/tb_dns_name_label_encoder_top.sv
